// ----- rtl/swff_pkg.sv -----
// Package for the shallow-water face flux block: number format constants,
// operand/opcode types, saturating arithmetic helpers and the microcode ROM.
// No dependencies.
package swff_pkg;

  localparam int WORD_W    = 32;
  localparam int FRAC_W    = 20;
  localparam int DVD_W     = WORD_W + FRAC_W;      // divider dividend width
  localparam int MAG_W     = DVD_W + 1;            // widest magnitude to saturate
  localparam int UPC_W     = 6;

  localparam logic signed [WORD_W-1:0] Q_ONE     = WORD_W'(1) << FRAC_W;
  localparam logic signed [WORD_W-1:0] Q_HALF    = WORD_W'(1) << (FRAC_W - 1);
  localparam logic signed [WORD_W-1:0] Q_QUARTER = WORD_W'(1) << (FRAC_W - 2);
  localparam logic signed [WORD_W-1:0] Q_EPS     = WORD_W'(10);
  localparam logic signed [WORD_W-1:0] Q_MAX     = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic signed [WORD_W-1:0] Q_MIN     = {1'b1, {(WORD_W-1){1'b0}}};
  localparam logic [30:0]              GRAV_RST  = 31'd10286285;

  // Microcode program: two velocity divides, then the flux sequence
  localparam logic [UPC_W-1:0] UC_CELL_END = 6'd1;
  localparam logic [UPC_W-1:0] UC_FLUX     = 6'd2;
  localparam logic [UPC_W-1:0] UC_LAST     = 6'd52;

  typedef enum logic [2:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_LIM
  } op_t;

  typedef enum logic [5:0] {
    R_HALF, R_QUARTER, R_GRAV,
    R_OD, R_OU, R_OV, R_ODF0, R_ODF1, R_ODF2,
    R_ND, R_NU, R_NV, R_NDF0, R_NDF1, R_NDF2, R_NNX, R_NNY,
    R_IH, R_IMX, R_IMY, R_IDF0, R_IDF1, R_IDF2,
    R_TA, R_TB, R_TC,
    R_HL, R_UL, R_VL, R_HR, R_UR, R_VR,
    R_QL, R_QR, R_GH, R_F0, R_F1, R_F2, R_VX, R_VY
  } reg_t;

  typedef struct packed {
    op_t  op;
    reg_t sa;
    reg_t sb;
    reg_t dst;
  } uop_t;

  // Saturating add or subtract; returns {saturated, value}
  function automatic logic [WORD_W:0] sat_add(input logic signed [WORD_W-1:0] a,
                                              input logic signed [WORD_W-1:0] b,
                                              input logic                     sub);
    logic signed [WORD_W:0] s;
    begin
      s = sub ? ({a[WORD_W-1], a} - {b[WORD_W-1], b}) : ({a[WORD_W-1], a} + {b[WORD_W-1], b});
      if (s[WORD_W] != s[WORD_W-1]) begin
        sat_add = {1'b1, (s[WORD_W] ? Q_MIN : Q_MAX)};
      end else begin
        sat_add = {1'b0, s[WORD_W-1:0]};
      end
    end
  endfunction

  // Apply sign to a magnitude with saturation; returns {saturated, value}
  function automatic logic [WORD_W:0] sat_mag(input logic [MAG_W-1:0] m, input logic neg);
    logic [MAG_W-1:0] lim;
    begin
      lim = MAG_W'(Q_MAX);
      if (neg) begin
        if (m > lim + MAG_W'(1)) sat_mag = {1'b1, Q_MIN};
        else                     sat_mag = {1'b0, WORD_W'(-m[WORD_W-1:0])};
      end else begin
        if (m > lim) sat_mag = {1'b1, Q_MAX};
        else         sat_mag = {1'b0, m[WORD_W-1:0]};
      end
    end
  endfunction

  function automatic logic [WORD_W-1:0] mag(input logic signed [WORD_W-1:0] a);
    begin
      mag = a[WORD_W-1] ? (~a + WORD_W'(1)) : a;
    end
  endfunction

  function automatic uop_t mk(input op_t op, input reg_t sa, input reg_t sb, input reg_t dst);
    begin
      mk = '{op: op, sa: sa, sb: sb, dst: dst};
    end
  endfunction

  function automatic uop_t uc_rom(input logic [UPC_W-1:0] pc);
    begin
      case (pc)
        6'd0:  uc_rom = mk(OP_DIV, R_IMX,     R_IH,   R_VX);
        6'd1:  uc_rom = mk(OP_DIV, R_IMY,     R_IH,   R_VY);
        // depth reconstruction
        6'd2:  uc_rom = mk(OP_LIM, R_NDF0,    R_ODF0, R_TB);
        6'd3:  uc_rom = mk(OP_MUL, R_HALF,    R_ODF0, R_TA);
        6'd4:  uc_rom = mk(OP_MUL, R_TA,      R_TB,   R_TA);
        6'd5:  uc_rom = mk(OP_ADD, R_OD,      R_TA,   R_HL);
        6'd6:  uc_rom = mk(OP_LIM, R_IDF0,    R_NDF0, R_TB);
        6'd7:  uc_rom = mk(OP_MUL, R_HALF,    R_NDF0, R_TA);
        6'd8:  uc_rom = mk(OP_MUL, R_TA,      R_TB,   R_TA);
        6'd9:  uc_rom = mk(OP_SUB, R_ND,      R_TA,   R_HR);
        // x velocity reconstruction
        6'd10: uc_rom = mk(OP_LIM, R_NDF1,    R_ODF1, R_TB);
        6'd11: uc_rom = mk(OP_MUL, R_HALF,    R_ODF1, R_TA);
        6'd12: uc_rom = mk(OP_MUL, R_TA,      R_TB,   R_TA);
        6'd13: uc_rom = mk(OP_ADD, R_OU,      R_TA,   R_UL);
        6'd14: uc_rom = mk(OP_LIM, R_IDF1,    R_NDF1, R_TB);
        6'd15: uc_rom = mk(OP_MUL, R_HALF,    R_NDF1, R_TA);
        6'd16: uc_rom = mk(OP_MUL, R_TA,      R_TB,   R_TA);
        6'd17: uc_rom = mk(OP_SUB, R_NU,      R_TA,   R_UR);
        // y velocity reconstruction
        6'd18: uc_rom = mk(OP_LIM, R_NDF2,    R_ODF2, R_TB);
        6'd19: uc_rom = mk(OP_MUL, R_HALF,    R_ODF2, R_TA);
        6'd20: uc_rom = mk(OP_MUL, R_TA,      R_TB,   R_TA);
        6'd21: uc_rom = mk(OP_ADD, R_OV,      R_TA,   R_VL);
        6'd22: uc_rom = mk(OP_LIM, R_IDF2,    R_NDF2, R_TB);
        6'd23: uc_rom = mk(OP_MUL, R_HALF,    R_NDF2, R_TA);
        6'd24: uc_rom = mk(OP_MUL, R_TA,      R_TB,   R_TA);
        6'd25: uc_rom = mk(OP_SUB, R_NV,      R_TA,   R_VR);
        // normal mass fluxes
        6'd26: uc_rom = mk(OP_MUL, R_UL,      R_NNX,  R_TA);
        6'd27: uc_rom = mk(OP_MUL, R_VL,      R_NNY,  R_TB);
        6'd28: uc_rom = mk(OP_ADD, R_TA,      R_TB,   R_TA);
        6'd29: uc_rom = mk(OP_MUL, R_TA,      R_HL,   R_QL);
        6'd30: uc_rom = mk(OP_MUL, R_UR,      R_NNX,  R_TA);
        6'd31: uc_rom = mk(OP_MUL, R_VR,      R_NNY,  R_TB);
        6'd32: uc_rom = mk(OP_ADD, R_TA,      R_TB,   R_TA);
        6'd33: uc_rom = mk(OP_MUL, R_TA,      R_HR,   R_QR);
        // hydrostatic term
        6'd34: uc_rom = mk(OP_MUL, R_QUARTER, R_GRAV, R_TC);
        6'd35: uc_rom = mk(OP_MUL, R_HL,      R_HL,   R_TA);
        6'd36: uc_rom = mk(OP_MUL, R_HR,      R_HR,   R_TB);
        6'd37: uc_rom = mk(OP_ADD, R_TA,      R_TB,   R_TA);
        6'd38: uc_rom = mk(OP_MUL, R_TC,      R_TA,   R_GH);
        // mass flux
        6'd39: uc_rom = mk(OP_ADD, R_QL,      R_QR,   R_TA);
        6'd40: uc_rom = mk(OP_MUL, R_HALF,    R_TA,   R_F0);
        // x momentum flux
        6'd41: uc_rom = mk(OP_MUL, R_QL,      R_UL,   R_TA);
        6'd42: uc_rom = mk(OP_MUL, R_QR,      R_UR,   R_TB);
        6'd43: uc_rom = mk(OP_ADD, R_TA,      R_TB,   R_TA);
        6'd44: uc_rom = mk(OP_MUL, R_HALF,    R_TA,   R_TA);
        6'd45: uc_rom = mk(OP_MUL, R_GH,      R_NNX,  R_TB);
        6'd46: uc_rom = mk(OP_ADD, R_TA,      R_TB,   R_F1);
        // y momentum flux
        6'd47: uc_rom = mk(OP_MUL, R_QL,      R_VL,   R_TA);
        6'd48: uc_rom = mk(OP_MUL, R_QR,      R_VR,   R_TB);
        6'd49: uc_rom = mk(OP_ADD, R_TA,      R_TB,   R_TA);
        6'd50: uc_rom = mk(OP_MUL, R_HALF,    R_TA,   R_TA);
        6'd51: uc_rom = mk(OP_MUL, R_GH,      R_NNY,  R_TB);
        6'd52: uc_rom = mk(OP_ADD, R_TA,      R_TB,   R_F2);
        default: uc_rom = mk(OP_ADD, R_TA,    R_TB,   R_F2);
      endcase
    end
  endfunction

endpackage

// ----- rtl/shallow_water_face_flux.sv -----
// Shallow-water face flux over one grid line: a microcoded sequencer driving one
// shared add/multiply/divide datapath. Depends on swff_pkg.
// A cell without a flux runs two divides (skipped for a zero depth) and a done step.
// A flux adds 31 multiplies, 14 adds and six limiters, each limiter dividing when
// none of its short cases applies. Throughput: one word at a time; in_tready
// returns after the done step, which a held result word stalls. Reset (rst_n low,
// synchronous) empties the window, drops any pending result and restores gravity
// to 9.81.
module shallow_water_face_flux (
  input  logic         clk,
  input  logic         rst_n,
  // configuration: gravity, Q11.20 unsigned
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [30:0]  cfg_data,
  // input cells
  input  logic         in_tvalid,
  output logic         in_tready,
  // depth, momentum_x, momentum_y, diff_depth, diff_vel_x, diff_vel_y, face_nx, face_ny
  input  logic [255:0] in_tdata,
  input  logic [0:0]   in_tuser,   // line_start
  // face fluxes
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [95:0]  out_tdata,  // flux_mass, flux_mom_x, flux_mom_y
  output logic [0:0]   out_tuser   // status
);
  import swff_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_FETCH = 7'b0000010,
    ST_EXEC  = 7'b0000100,
    ST_MUL   = 7'b0001000,
    ST_LIM   = 7'b0010000,
    ST_DIV   = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  localparam logic [5:0] DIV_STEPS = 6'(DVD_W);

  state_t state_r;
  logic [UPC_W-1:0] upc_r;
  logic [30:0] grav_r;
  logic [1:0]  fill_r;
  logic        osat_r, nsat_r, csat_r, sat_r;

  // window and captured cell
  logic signed [WORD_W-1:0] od_r, ou_r, ov_r, odf0_r, odf1_r, odf2_r;
  logic signed [WORD_W-1:0] nd_r, nu_r, nv_r, ndf0_r, ndf1_r, ndf2_r, nnx_r, nny_r;
  logic signed [WORD_W-1:0] ih_r, imx_r, imy_r, idf0_r, idf1_r, idf2_r, inx_r, iny_r;
  // scratch
  logic signed [WORD_W-1:0] ta_r, tb_r, tc_r, hl_r, ul_r, vl_r, hr_r, ur_r, vr_r;
  logic signed [WORD_W-1:0] ql_r, qr_r, gh_r, f0_r, f1_r, f2_r, vx_r, vy_r;

  // shared unit
  uop_t uop;
  op_t  op_r;
  reg_t dst_r;
  logic signed [WORD_W-1:0] opa_r, opb_r;
  logic [2*WORD_W-1:0] prod_r;
  logic                mneg_r;
  logic [DVD_W-1:0]    dvd_r;
  logic [WORD_W-1:0]   rem_r, dy_r;
  logic                dneg_r;
  logic [5:0]          div_cnt_r;

  logic                out_valid_r;
  logic [95:0]         out_data_r;
  logic                out_stat_r;

  logic in_fire, flux_cell;
  logic wb_en, wb_sat, div_go;
  logic signed [WORD_W-1:0] wb_val;
  logic [WORD_W:0] add_res, den_res, mul_res, div_res;
  logic [2*WORD_W-1:0] mul_rnd;
  logic [WORD_W:0] rem_sh;
  logic div_ge, div_rnd;
  logic [MAG_W-1:0] div_m;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_stat_r;
  assign flux_cell  = (fill_r == 2'd2);
  assign uop        = uc_rom(upc_r);

  // Operand select
  function automatic logic signed [WORD_W-1:0] rd(input reg_t s);
    begin
      case (s)
        R_HALF:    rd = Q_HALF;
        R_QUARTER: rd = Q_QUARTER;
        R_GRAV:    rd = {1'b0, grav_r};
        R_OD:      rd = od_r;
        R_OU:      rd = ou_r;
        R_OV:      rd = ov_r;
        R_ODF0:    rd = odf0_r;
        R_ODF1:    rd = odf1_r;
        R_ODF2:    rd = odf2_r;
        R_ND:      rd = nd_r;
        R_NU:      rd = nu_r;
        R_NV:      rd = nv_r;
        R_NDF0:    rd = ndf0_r;
        R_NDF1:    rd = ndf1_r;
        R_NDF2:    rd = ndf2_r;
        R_NNX:     rd = nnx_r;
        R_NNY:     rd = nny_r;
        R_IH:      rd = ih_r;
        R_IMX:     rd = imx_r;
        R_IMY:     rd = imy_r;
        R_IDF0:    rd = idf0_r;
        R_IDF1:    rd = idf1_r;
        R_IDF2:    rd = idf2_r;
        R_TA:      rd = ta_r;
        R_TB:      rd = tb_r;
        R_TC:      rd = tc_r;
        R_HL:      rd = hl_r;
        R_UL:      rd = ul_r;
        R_VL:      rd = vl_r;
        R_HR:      rd = hr_r;
        R_UR:      rd = ur_r;
        R_VR:      rd = vr_r;
        R_QL:      rd = ql_r;
        R_QR:      rd = qr_r;
        R_GH:      rd = gh_r;
        R_F0:      rd = f0_r;
        R_F1:      rd = f1_r;
        R_F2:      rd = f2_r;
        R_VX:      rd = vx_r;
        R_VY:      rd = vy_r;
        default:   rd = '0;
      endcase
    end
  endfunction

  // Datapath results
  assign add_res = sat_add(opa_r, opb_r, op_r == OP_SUB);
  assign den_res = sat_add(opb_r, Q_EPS, 1'b0);
  assign mul_rnd = prod_r + (64'(1) << (FRAC_W - 1));
  assign mul_res = sat_mag(MAG_W'(mul_rnd[2*WORD_W-1:FRAC_W]), mneg_r);
  assign rem_sh  = {rem_r, dvd_r[DVD_W-1]};
  assign div_ge  = rem_sh >= {1'b0, dy_r};
  assign div_rnd = {rem_r, 1'b0} >= {1'b0, dy_r};
  assign div_m   = {1'b0, dvd_r} + MAG_W'(div_rnd);
  assign div_res = sat_mag(div_m, dneg_r);

  // Write-back and divider launch
  always_comb begin
    wb_en  = 1'b0;
    wb_sat = 1'b0;
    wb_val = '0;
    div_go = 1'b0;
    case (state_r)
      ST_EXEC: begin
        case (op_r)
          OP_ADD, OP_SUB: begin
            wb_en = 1'b1;
            {wb_sat, wb_val} = add_res;
          end
          OP_DIV: begin
            if (opb_r == '0) begin
              wb_en  = 1'b1;
              wb_sat = 1'b1;
              wb_val = (opa_r > 0) ? Q_MAX : ((opa_r < 0) ? Q_MIN : '0);
            end else begin
              div_go = 1'b1;
            end
          end
          default: ;
        endcase
      end
      ST_MUL: begin
        wb_en = 1'b1;
        {wb_sat, wb_val} = mul_res;
      end
      ST_LIM: begin
        // opb holds the biased denominator here
        if (opb_r == '0) begin
          wb_en  = 1'b1;
          wb_val = (opa_r >= 0) ? Q_ONE : '0;
        end else if (opa_r == '0 || (opa_r[WORD_W-1] != opb_r[WORD_W-1])) begin
          wb_en = 1'b1;
        end else if (mag(opa_r) >= mag(opb_r)) begin
          wb_en  = 1'b1;
          wb_val = Q_ONE;
        end else begin
          div_go = 1'b1;
        end
      end
      ST_DIV: begin
        if (div_cnt_r == DIV_STEPS) begin
          wb_en = 1'b1;
          {wb_sat, wb_val} = div_res;
        end
      end
      default: ;
    endcase
  end

  // Control: sequencer, window, config, output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      upc_r       <= '0;
      grav_r      <= GRAV_RST;
      fill_r      <= '0;
      osat_r      <= 1'b0;
      nsat_r      <= 1'b0;
      csat_r      <= 1'b0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) grav_r <= cfg_data;
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;

      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            upc_r   <= '0;
            sat_r   <= 1'b0;
            if (in_tuser[0]) fill_r <= '0;
            state_r <= ST_FETCH;
          end
        end
        ST_FETCH: state_r <= ST_EXEC;
        ST_EXEC: begin
          case (op_r)
            OP_MUL:  state_r <= ST_MUL;
            OP_LIM: begin
              sat_r   <= sat_r | den_res[WORD_W];
              state_r <= ST_LIM;
            end
            default: ;
          endcase
        end
        ST_DONE: begin
          if (!flux_cell || !out_valid_r || out_tready) begin
            if (flux_cell) begin
              out_valid_r <= 1'b1;
            end
            osat_r  <= nsat_r;
            nsat_r  <= csat_r;
            fill_r  <= flux_cell ? fill_r : fill_r + 2'd1;
            state_r <= ST_IDLE;
          end
        end
        default: ;
      endcase

      if (div_go) state_r <= ST_DIV;

      // advance or end the program on every write-back
      if (wb_en) begin
        sat_r <= sat_r | wb_sat;
        if (upc_r == UC_CELL_END) begin
          csat_r <= sat_r | wb_sat;
          if (flux_cell) begin
            sat_r   <= osat_r | nsat_r;
            upc_r   <= UC_FLUX;
            state_r <= ST_FETCH;
          end else begin
            state_r <= ST_DONE;
          end
        end else if (upc_r == UC_LAST) begin
          state_r <= ST_DONE;
        end else begin
          upc_r   <= upc_r + 1'b1;
          state_r <= ST_FETCH;
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    // capture the incoming cell
    if (in_fire) begin
      ih_r   <= in_tdata[31:0];
      imx_r  <= in_tdata[63:32];
      imy_r  <= in_tdata[95:64];
      idf0_r <= in_tdata[127:96];
      idf1_r <= in_tdata[159:128];
      idf2_r <= in_tdata[191:160];
      inx_r  <= in_tdata[223:192];
      iny_r  <= in_tdata[255:224];
    end

    // fetch operands
    if (state_r == ST_FETCH) begin
      opa_r <= rd(uop.sa);
      opb_r <= rd(uop.sb);
      op_r  <= uop.op;
      dst_r <= uop.dst;
    end

    // multiplier stage
    if (state_r == ST_EXEC && op_r == OP_MUL) begin
      prod_r <= mag(opa_r) * mag(opb_r);
      mneg_r <= opa_r[WORD_W-1] ^ opb_r[WORD_W-1];
    end

    // hold biased limiter denominator
    if (state_r == ST_EXEC && op_r == OP_LIM) begin
      opb_r <= den_res[WORD_W-1:0];
    end

    // restoring divider, one quotient bit per cycle
    if (div_go) begin
      dvd_r     <= {mag(opa_r), {FRAC_W{1'b0}}};
      rem_r     <= '0;
      dy_r      <= mag(opb_r);
      dneg_r    <= opa_r[WORD_W-1] ^ opb_r[WORD_W-1];
      div_cnt_r <= '0;
    end else if (state_r == ST_DIV && div_cnt_r != DIV_STEPS) begin
      rem_r     <= div_ge ? WORD_W'(rem_sh - {1'b0, dy_r}) : rem_sh[WORD_W-1:0];
      dvd_r     <= {dvd_r[DVD_W-2:0], div_ge};
      div_cnt_r <= div_cnt_r + 6'd1;
    end

    // write back
    if (wb_en) begin
      case (dst_r)
        R_TA: ta_r <= wb_val;
        R_TB: tb_r <= wb_val;
        R_TC: tc_r <= wb_val;
        R_HL: hl_r <= wb_val;
        R_UL: ul_r <= wb_val;
        R_VL: vl_r <= wb_val;
        R_HR: hr_r <= wb_val;
        R_UR: ur_r <= wb_val;
        R_VR: vr_r <= wb_val;
        R_QL: ql_r <= wb_val;
        R_QR: qr_r <= wb_val;
        R_GH: gh_r <= wb_val;
        R_F0: f0_r <= wb_val;
        R_F1: f1_r <= wb_val;
        R_F2: f2_r <= wb_val;
        R_VX: vx_r <= wb_val;
        R_VY: vy_r <= wb_val;
        default: ;
      endcase
    end

    // shift the window and load the result word
    if (state_r == ST_DONE && (!flux_cell || !out_valid_r || out_tready)) begin
      od_r   <= nd_r;
      ou_r   <= nu_r;
      ov_r   <= nv_r;
      odf0_r <= ndf0_r;
      odf1_r <= ndf1_r;
      odf2_r <= ndf2_r;
      nd_r   <= ih_r;
      nu_r   <= vx_r;
      nv_r   <= vy_r;
      ndf0_r <= idf0_r;
      ndf1_r <= idf1_r;
      ndf2_r <= idf2_r;
      nnx_r  <= inx_r;
      nny_r  <= iny_r;
      if (flux_cell) begin
        out_data_r <= {f2_r, f1_r, f0_r};
        out_stat_r <= sat_r;
      end
    end
  end

  // Checks
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result word raised outside the done step");

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r != 2'd3)
    else $error("window fill count out of range");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (div_cnt_r <= DIV_STEPS))
    else $error("divider ran past its step count");

  a_accept_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_FETCH && upc_r == '0))
    else $error("accepted word did not start the program");

  a_upc_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FETCH) |-> (upc_r <= UC_LAST))
    else $error("program counter beyond last step");

endmodule
